// File: src/pst_pkg.sv
// Shared constants and types for the priority schedule timing block.
// No dependencies; imported by the top level and by the testbench checker.
package pst_pkg;

    localparam int BURST_W = 16;
    localparam int PRIO_W  = 8;
    localparam int ARR_W   = 6;
    localparam int POS_W   = 7;
    localparam int TIME_W  = 22;
    localparam int AVG_W   = 30;
    localparam int FRAC_W  = 8;
    localparam int ENTRY_W = BURST_W + PRIO_W + ARR_W;
    localparam int KEY_W   = PRIO_W + ARR_W;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 144;

    localparam logic [2:0] ST_LOAD = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_SEL  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;

    typedef struct packed {
        logic [BURST_W-1:0] burst;
        logic [PRIO_W-1:0]  prio;
        logic [ARR_W-1:0]   arr;
    } entry_t;

    typedef struct packed {
        logic [AVG_W-1:0]  avg_turn;
        logic [AVG_W-1:0]  avg_wait;
        logic [TIME_W-1:0] turn;
        logic [TIME_W-1:0] wait_t;
        logic [PRIO_W-1:0] prio;
        logic [BURST_W-1:0] burst;
        logic [POS_W-1:0]  arr_idx;
        logic [POS_W-1:0]  pos;
    } result_t;

endpackage

// File: src/pst_ram.sv
// Generic single-port-write, registered-read RAM.
// Depends on nothing.
module pst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        aclk,
    input  logic                                        wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                            wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                            rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
endmodule

// File: src/pst_div.sv
// Bit-serial restoring divider: two dividends over one shared divisor.
// Depends on nothing; one quotient bit per cycle.
module pst_div #(
    parameter int DW = 37,
    parameter int VW = 5
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [DW-1:0] dividend_a,
    input  logic [DW-1:0] dividend_b,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quot_a,
    output logic [DW-1:0] quot_b
);
    localparam int CNT_W = $clog2(DW + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg, done_reg;
    logic [VW-1:0]    rem_a_reg, rem_b_reg;
    logic [DW-1:0]    q_a_reg, q_b_reg;
    logic [VW:0]      t_a, t_b, d_ext, r_a, r_b;
    logic             ge_a, ge_b;

    always_comb begin
        d_ext = {1'b0, divisor};
        t_a   = {rem_a_reg, q_a_reg[DW-1]};
        t_b   = {rem_b_reg, q_b_reg[DW-1]};
        ge_a  = (t_a >= d_ext);
        ge_b  = (t_b >= d_ext);
        r_a   = ge_a ? (t_a - d_ext) : t_a;
        r_b   = ge_b ? (t_b - d_ext) : t_b;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_a_reg <= '0;
            rem_b_reg <= '0;
            q_a_reg   <= dividend_a;
            q_b_reg   <= dividend_b;
        end else if (busy_reg) begin
            // The remainder stays below the divisor, so it fits VW bits.
            rem_a_reg <= r_a[VW-1:0];
            rem_b_reg <= r_b[VW-1:0];
            q_a_reg   <= {q_a_reg[DW-2:0], ge_a};
            q_b_reg   <= {q_b_reg[DW-2:0], ge_b};
        end
    end

    assign done   = done_reg;
    assign quot_a = q_a_reg;
    assign quot_b = q_b_reg;
endmodule

// File: src/priority_schedule_timing.sv
// Top level of the non-preemptive priority scheduling timing block.
// Depends on pst_pkg, pst_ram and pst_div.
//
// Channel  Dir  tdata (low bit up)                              tlast          tuser
// s_       in   burst_time[15:0], job_priority[23:16]           last_job       -
// m_       out  service_position, arrival_index, job_burst,     final_result   jobs_dropped
//               job_prio, waiting_time, turnaround_time,
//               avg_waiting_fx, avg_turnaround_fx
//
// Jobs load one per cycle into the job RAM while the block is in its load
// state. After the last job the block runs a selection scan over the RAM
// twice: once to total the times, once to emit. Between the two the serial
// divider holds the block while it forms both averages (35 quotient bits,
// one per cycle). Reset is synchronous and clears control state only.
// A stalled result holds the emit scan; the next set may load while the final
// result still waits.
module priority_schedule_timing
    import pst_pkg::*;
#(
    parameter int MAX_PROCS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // burst_time, job_priority
    input  logic                s_tlast,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // see table above
    output logic                m_tlast,
    output logic                m_tuser    // jobs_dropped
);
    localparam int CW   = $clog2(MAX_PROCS + 1);
    localparam int AW   = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int TW   = TIME_W + CW;
    localparam int DIVW = TW + FRAC_W;

    logic [2:0]        state_reg, state_next;
    logic [CW-1:0]     count_reg, scan_reg, pos_reg;
    logic              ovf_reg, pass_reg;
    logic              rd_valid_reg;
    logic              lo_valid_reg, best_valid_reg;
    logic [KEY_W-1:0]  lo_key_reg, best_key_reg;
    logic [BURST_W-1:0] best_burst_reg;
    logic [TIME_W-1:0] elapsed_reg;
    logic [TW-1:0]     tot_wait_reg, tot_turn_reg;
    logic [AVG_W-1:0]  avg_w_reg, avg_t_reg;
    logic              div_start_reg;
    result_t           res_reg;
    logic              m_valid_reg, m_last_reg, m_user_reg;

    logic              s_fire, out_free, issue, better, emit;
    logic [AW-1:0]     wr_addr;
    entry_t            wr_entry, rd_entry;
    logic [ENTRY_W-1:0] rd_raw;
    logic [KEY_W-1:0]  rd_key;
    logic [TIME_W-1:0] elapsed_plus;
    logic              div_done;
    logic [DIVW-1:0]   q_a, q_b;

    assign s_tready = (state_reg == ST_LOAD);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign issue    = (state_reg == ST_SCAN) && (scan_reg < count_reg);
    assign wr_addr  = count_reg[AW-1:0];

    always_comb begin
        wr_entry.burst = s_tdata[BURST_W-1:0];
        wr_entry.prio  = s_tdata[BURST_W+PRIO_W-1:BURST_W];
        wr_entry.arr   = ARR_W'(count_reg);
    end

    pst_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_PROCS)) u_ram (
        .aclk    (aclk),
        .wr_en   (s_fire && (count_reg < CW'(MAX_PROCS))),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_addr (scan_reg[AW-1:0]),
        .rd_data (rd_raw)
    );

    assign rd_entry = entry_t'(rd_raw);
    assign rd_key   = {rd_entry.prio, rd_entry.arr};
    // Candidate must lie above the last key served and below the best so far.
    assign better   = rd_valid_reg && (!lo_valid_reg || (rd_key > lo_key_reg))
                      && (!best_valid_reg || (rd_key < best_key_reg));
    assign elapsed_plus = elapsed_reg + TIME_W'(best_burst_reg);
    assign emit     = (state_reg == ST_SEL) && pass_reg && out_free;

    pst_div #(.DW(DIVW), .VW(CW)) u_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (div_start_reg),
        .dividend_a ({tot_wait_reg, {FRAC_W{1'b0}}}),
        .dividend_b ({tot_turn_reg, {FRAC_W{1'b0}}}),
        .divisor    (count_reg),
        .done       (div_done),
        .quot_a     (q_a),
        .quot_b     (q_b)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD: if (s_fire && s_tlast) state_next = ST_SCAN;
            ST_SCAN: if (rd_valid_reg && (scan_reg == count_reg)) state_next = ST_SEL;
            ST_SEL: begin
                if (!pass_reg) begin
                    state_next = (pos_reg + 1'b1 == count_reg) ? ST_DIV : ST_SCAN;
                end else if (out_free) begin
                    state_next = (pos_reg + 1'b1 == count_reg) ? ST_LOAD : ST_SCAN;
                end
            end
            ST_DIV:  if (div_done) state_next = ST_SCAN;
            default: state_next = ST_LOAD;
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_LOAD;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            pass_reg       <= 1'b0;
            scan_reg       <= '0;
            pos_reg        <= '0;
            rd_valid_reg   <= 1'b0;
            lo_valid_reg   <= 1'b0;
            best_valid_reg <= 1'b0;
            div_start_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg     <= state_next;
            rd_valid_reg  <= issue;
            div_start_reg <= 1'b0;
            if (m_tready) m_valid_reg <= 1'b0;
            if (issue) scan_reg <= scan_reg + 1'b1;
            if (better) best_valid_reg <= 1'b1;
            case (state_reg)
                ST_LOAD: begin
                    if (s_fire) begin
                        // Drop the job when full; remember the drop for the set.
                        if (count_reg < CW'(MAX_PROCS)) count_reg <= count_reg + 1'b1;
                        else ovf_reg <= 1'b1;
                        if (s_tlast) begin
                            pass_reg       <= 1'b0;
                            scan_reg       <= '0;
                            pos_reg        <= '0;
                            lo_valid_reg   <= 1'b0;
                            best_valid_reg <= 1'b0;
                        end
                    end
                end
                ST_SEL: begin
                    if (!pass_reg || out_free) begin
                        lo_valid_reg   <= 1'b1;
                        best_valid_reg <= 1'b0;
                        scan_reg       <= '0;
                        pos_reg        <= pos_reg + 1'b1;
                        if (pos_reg + 1'b1 == count_reg) begin
                            // Restart position tracking for the next pass.
                            lo_valid_reg <= 1'b0;
                            pos_reg      <= '0;
                            if (!pass_reg) begin
                                div_start_reg <= 1'b1;
                            end else begin
                                count_reg <= '0;
                                ovf_reg   <= 1'b0;
                            end
                        end
                    end
                    if (emit) m_valid_reg <= 1'b1;
                end
                ST_DIV: if (div_done) pass_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (better) begin
            best_key_reg   <= rd_key;
            best_burst_reg <= rd_entry.burst;
        end
        if (state_reg == ST_LOAD && s_fire && s_tlast) begin
            elapsed_reg  <= '0;
            tot_wait_reg <= '0;
            tot_turn_reg <= '0;
        end
        if (state_reg == ST_SEL && (!pass_reg || out_free)) begin
            lo_key_reg  <= best_key_reg;
            elapsed_reg <= elapsed_plus;
            if (pos_reg + 1'b1 == count_reg) elapsed_reg <= '0;
            if (!pass_reg) begin
                tot_wait_reg <= tot_wait_reg + TW'(elapsed_reg);
                tot_turn_reg <= tot_turn_reg + TW'(elapsed_plus);
            end
        end
        if (state_reg == ST_DIV && div_done) begin
            avg_w_reg <= q_a[AVG_W-1:0];
            avg_t_reg <= q_b[AVG_W-1:0];
        end
        if (emit) begin
            res_reg.pos      <= POS_W'(pos_reg) + 1'b1;
            res_reg.arr_idx  <= POS_W'(best_key_reg[ARR_W-1:0]) + 1'b1;
            res_reg.burst    <= best_burst_reg;
            res_reg.prio     <= best_key_reg[KEY_W-1:ARR_W];
            res_reg.wait_t   <= elapsed_reg;
            res_reg.turn     <= elapsed_plus;
            res_reg.avg_wait <= avg_w_reg;
            res_reg.avg_turn <= avg_t_reg;
            m_last_reg       <= (pos_reg + 1'b1 == count_reg);
            m_user_reg       <= ovf_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_DATA_W - $bits(result_t)){1'b0}}, res_reg};
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_PROCS))
        else $error("job count exceeds capacity");

    a_emit_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> (pos_reg < count_reg))
        else $error("result emitted beyond stored jobs");

    a_div_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside its phase");

    a_no_load_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_tlast) |=> (state_reg == ST_SCAN && !pass_reg))
        else $error("schedule did not start after last job");
`endif
endmodule

// File: tb/pst_checker.sv
// Checker for the priority schedule timing block: predicts the schedule of each job set
// from the accepted input transactions and compares every result transaction.
// Depends on pst_pkg; instantiated by tb_priority_schedule_timing.
module pst_checker
    import pst_pkg::*;
#(
    parameter int MAX_PROCS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                s_tlast,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [M_DATA_W-1:0] m_tdata,
    input  logic                m_tlast,
    input  logic                m_tuser,
    output int                  fail_count,
    output int                  pending_count
);

    typedef struct packed {
        result_t    res;
        logic       fin;
        logic       dropped;
    } sched_t;

    logic [BURST_W-1:0] job_burst_q [MAX_PROCS];
    logic [PRIO_W-1:0]  job_prio_q  [MAX_PROCS];
    int                 stored_jobs;
    logic               lost_job;
    sched_t             schedule_q [$];

    // Build the service order and timing of the stored set and queue its results.
    task automatic schedule_set(input int cnt, input logic dropped);
        int          order [MAX_PROCS];
        int          j;
        int          cur;
        longint      elapsed;
        longint      sum_wait;
        longint      sum_turn;
        longint      avg_w;
        longint      avg_t;
        sched_t      s;
        for (int i = 0; i < cnt; i++) begin
            cur = i;
            j = i;
            while (j > 0 && job_prio_q[order[j-1]] > job_prio_q[cur]) begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = cur;
        end
        elapsed = 0; sum_wait = 0; sum_turn = 0;
        for (int i = 0; i < cnt; i++) begin
            sum_wait += elapsed;
            elapsed  += job_burst_q[order[i]];
            sum_turn += elapsed;
        end
        avg_w = (sum_wait << FRAC_W) / cnt;
        avg_t = (sum_turn << FRAC_W) / cnt;
        elapsed = 0;
        for (int i = 0; i < cnt; i++) begin
            s.res.pos      = POS_W'(i + 1);
            s.res.arr_idx  = POS_W'(order[i] + 1);
            s.res.burst    = job_burst_q[order[i]];
            s.res.prio     = job_prio_q[order[i]];
            s.res.wait_t   = TIME_W'(elapsed);
            s.res.turn     = TIME_W'(elapsed + job_burst_q[order[i]]);
            s.res.avg_wait = AVG_W'(avg_w);
            s.res.avg_turn = AVG_W'(avg_t);
            s.fin          = (i + 1 == cnt);
            s.dropped      = dropped;
            schedule_q.push_back(s);
            elapsed += job_burst_q[order[i]];
        end
    endtask

    task automatic check_field(input string name, input longint exp_v, input longint act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        sched_t  e;
        result_t got;
        if (!aresetn) begin
            stored_jobs   = 0;
            lost_job      = 1'b0;
            fail_count    = 0;
            pending_count = 0;
            schedule_q.delete();
        end else begin
            // Load side: store, drop when full, schedule on the last job.
            if (s_tvalid && s_tready) begin
                if (stored_jobs < MAX_PROCS) begin
                    job_burst_q[stored_jobs] = s_tdata[BURST_W-1:0];
                    job_prio_q[stored_jobs]  = s_tdata[BURST_W +: PRIO_W];
                    stored_jobs = stored_jobs + 1;
                end else begin
                    lost_job = 1'b1;
                end
                if (s_tlast) begin
                    if (stored_jobs > 0)
                        schedule_set(stored_jobs, lost_job);
                    stored_jobs = 0;
                    lost_job    = 1'b0;
                end
            end
            // Result side: compare against the oldest expectation.
            if (m_tvalid && m_tready) begin
                got = m_tdata[$bits(result_t)-1:0];
                if (schedule_q.size() == 0) begin
                    $error("result transaction with no expectation pending");
                    fail_count = fail_count + 1;
                end else begin
                    e = schedule_q.pop_front();
                    check_field("service_position", e.res.pos, got.pos);
                    check_field("arrival_index", e.res.arr_idx, got.arr_idx);
                    check_field("job_burst", e.res.burst, got.burst);
                    check_field("job_prio", e.res.prio, got.prio);
                    check_field("waiting_time", e.res.wait_t, got.wait_t);
                    check_field("turnaround_time", e.res.turn, got.turn);
                    check_field("avg_waiting_fx", e.res.avg_wait, got.avg_wait);
                    check_field("avg_turnaround_fx", e.res.avg_turn, got.avg_turn);
                    check_field("final_result", e.fin, m_tlast);
                    check_field("jobs_dropped", e.dropped, m_tuser);
                end
            end
            pending_count = schedule_q.size();
        end
    end

endmodule

// File: tb/tb_priority_schedule_timing.sv
// Top of the priority schedule timing testbench: clock, reset, job-set stimulus and verdict.
// Depends on pst_pkg, priority_schedule_timing and pst_checker.
module tb_priority_schedule_timing;
    import pst_pkg::*;

    localparam int MAX_PROCS   = 16;
    // Watchdog limit, set with ample room for a full set under stalls.
    localparam int QUIET_LIMIT = 20000;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                s_tlast;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tlast;
    logic                m_tuser;
    int                  fail_count;
    int                  pending_count;
    int                  idle_pct;      // percent chance that either side idles this cycle
    int                  quiet_cycles;

    priority_schedule_timing #(.MAX_PROCS(MAX_PROCS)) i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .m_tuser(m_tuser)
    );

    pst_checker #(.MAX_PROCS(MAX_PROCS)) i_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .m_tuser(m_tuser), .fail_count(fail_count), .pending_count(pending_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Receiver: stall at random, unless the idling rate is zero.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // Watchdog: end the run when no transaction moves for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb_priority_schedule_timing: done, errors");
                $finish;
            end
        end
    end

    // Offer one job, with random idle cycles ahead of it, and hold until accepted.
    task automatic send_job(input logic [BURST_W-1:0] burst, input logic [PRIO_W-1:0] prio,
                            input logic last);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {prio, burst};
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Send a set of n jobs; priorities drawn from a narrow range force ties.
    task automatic send_set(input int n, input int prio_span);
        logic [BURST_W-1:0] b;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(3))
                0: b = '1;
                1: b = BURST_W'($urandom_range(15));
                default: b = BURST_W'($urandom);
            endcase
            send_job(b, PRIO_W'($urandom_range(prio_span)), i == n - 1);
        end
    endtask

    // Let the checker take in the last accepted job before waiting on its results.
    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
    endtask

    initial begin
        int sent;
        int n;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        idle_pct = 25;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: single job at the extremes, zero bursts, equal priorities.
        send_job('1, '1, 1'b1);
        send_job('0, '0, 1'b1);
        send_job(16'd5, 8'd3, 1'b0);
        send_job(16'd7, 8'd3, 1'b0);
        send_job(16'd1, 8'd0, 1'b0);
        send_job(16'hAAAA, 8'hFF, 1'b0);
        send_job(16'h5555, 8'h55, 1'b1);
        drain;  // hold the sender until the set has come out

        // Directed: overflow, the last job itself dropped.
        send_set(MAX_PROCS + 2, 255);
        // Full store with all-ones bursts and all-equal priorities.
        for (int i = 0; i < MAX_PROCS; i++) send_job('1, 8'hAA, i == MAX_PROCS - 1);
        drain;

        // Random: long stretch with no idling, then idling at 25 percent.
        sent = 0;
        idle_pct = 0;
        while (sent < 180) begin
            if (sent > 60) idle_pct = 25;
            case ($urandom_range(9))
                0:       n = MAX_PROCS + $urandom_range(1, 3);
                1:       n = MAX_PROCS;
                default: n = $urandom_range(1, 6);
            endcase
            send_set(n, $urandom_range(1) ? 255 : 3);
            sent += n;
        end
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
        drain;
        repeat (100) @(posedge aclk);

        if (fail_count == 0) begin
            $display("tb_priority_schedule_timing: done, clean");
        end else begin
            $display("tb_priority_schedule_timing: done, errors");
        end
        $finish;
    end

endmodule
